@@ rtl/sui_pkg.sv @@
// sui_pkg: shared types, mode codes and defaults for the set union /
// intersection / difference block. No dependencies.
package sui_pkg;

	localparam int SET_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int ID_W          = 16;
	localparam int MODE_W        = 3;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_A  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD_B  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UNION  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INTER  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_A_DIFF = 3'd5;
	localparam logic [MODE_W-1:0] MODE_B_DIFF = 3'd6;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_ADD_A,
		OP_ADD_B,
		OP_UNION,
		OP_INTER,
		OP_A_DIFF,
		OP_B_DIFF
	} cmd_op_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   customer_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] member_id;
		logic            empty_res;
		logic            last;
	} rsp_t;

	typedef struct packed {
		cmd_op_t         op;
		logic [ID_W-1:0] id;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OUTER,
		ST_OLOAD,
		ST_SCAN,
		ST_EMIT,
		ST_FINISH
	} eng_state_t;

endpackage

@@ rtl/set_union_intersect_difference.sv @@
// set_union_intersect_difference: top level, front decoder, command queue
// and engine. Depends on sui_pkg, sui_front, sui_queue, sui_engine, sui_ram.
//
// The block keeps two ordered lists of identifiers, A and B, of up to
// SET_DEPTH entries each, in two small RAMs. A request item clears both
// lists, appends customer_id (kept to its low ID_BITS bits) to A or B, or
// asks for union, intersection, A minus B or B minus A; the unused mode is
// taken and ignored, and an append to a full list is dropped. Each query
// answers with one result item per member, the final one marked last; an
// empty answer is one item with empty_res set and member_id zero.
// Intersection repeats a member once per equal B entry and stops after
// 2*SET_DEPTH results. The front decodes request items into a two-entry
// command queue, so requests keep being taken, as long as the queue has
// room, while the engine works or while a result waits in the output
// register. For a query the engine walks one list in order and compares
// each entry against every entry of the other list (union walks A alone,
// then B against A): the engine makes one compare a cycle, reading the
// inner list one RAM entry per cycle. With two full lists union is the
// slowest query.
module set_union_intersect_difference #(
	parameter int SET_DEPTH = sui_pkg::SET_DEPTH_DEF,
	parameter int ID_BITS   = sui_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sui_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sui_pkg::rsp_t rsp
);

	logic             push;
	logic             full;
	logic             pop;
	sui_pkg::cmd_t    cmd;
	sui_pkg::q_head_t head;

	// decode the mode; unused mode never reaches the queue
	sui_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.full      (full),
		.push      (push),
		.cmd       (cmd)
	);

	// decouples request acceptance from the long query scans
	sui_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	// list storage, compare scan and result register
	sui_engine #(
		.SET_DEPTH (SET_DEPTH),
		.ID_BITS   (ID_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

@@ rtl/sui_ram.sv @@
// sui_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sui_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/sui_front.sv @@
// sui_front: accepts request items and decodes the mode into a command.
// Depends on sui_pkg.
module sui_front (
	input  logic          req_valid,
	output logic          req_ready,
	input  sui_pkg::req_t req,
	input  logic          full,
	output logic          push,
	output sui_pkg::cmd_t cmd
);

	logic keep;

	always_comb begin
		keep    = 1'b1;
		cmd.id  = req.customer_id;
		cmd.op  = sui_pkg::OP_CLEAR;
		case (req.mode)
			sui_pkg::MODE_CLEAR:  cmd.op = sui_pkg::OP_CLEAR;
			sui_pkg::MODE_ADD_A:  cmd.op = sui_pkg::OP_ADD_A;
			sui_pkg::MODE_ADD_B:  cmd.op = sui_pkg::OP_ADD_B;
			sui_pkg::MODE_UNION:  cmd.op = sui_pkg::OP_UNION;
			sui_pkg::MODE_INTER:  cmd.op = sui_pkg::OP_INTER;
			sui_pkg::MODE_A_DIFF: cmd.op = sui_pkg::OP_A_DIFF;
			sui_pkg::MODE_B_DIFF: cmd.op = sui_pkg::OP_B_DIFF;
			default: begin
				// unused mode: taken and dropped
				keep = 1'b0;
			end
		endcase
	end

	assign req_ready = !full;
	assign push      = req_valid && !full && keep;

endmodule

@@ rtl/sui_queue.sv @@
// sui_queue: short command FIFO between the front decoder and the engine.
// Depends on sui_pkg.
module sui_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sui_pkg::cmd_t    wdata,
	output logic             full,
	input  logic             pop,
	output sui_pkg::q_head_t head
);

	localparam int DEPTH = sui_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW   = $clog2(DEPTH + 1);

	sui_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CTW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
		return r;
	endfunction

	assign full       = (cnt_q == CTW'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CTW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CTW'(1);
			end
		end
	end

endmodule

@@ rtl/sui_engine.sv @@
// sui_engine: executes commands against the two set RAMs, runs the
// compare scan for queries and drives the result register.
// Depends on sui_pkg and sui_ram.
module sui_engine #(
	parameter int SET_DEPTH = sui_pkg::SET_DEPTH_DEF,
	parameter int ID_BITS   = sui_pkg::ID_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sui_pkg::q_head_t head,
	output logic             pop,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output sui_pkg::rsp_t    rsp
);

	localparam int AW      = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW      = $clog2(SET_DEPTH + 1);
	localparam int SW      = (ID_BITS < sui_pkg::ID_W) ? ID_BITS : sui_pkg::ID_W;
	localparam int MAX_RES = 2 * SET_DEPTH;
	localparam int EW      = $clog2(MAX_RES + 1);

	sui_pkg::eng_state_t state_q, state_d;
	sui_pkg::cmd_op_t    op_q;
	logic [CW-1:0]       cnt_a_q, cnt_b_q;
	logic [CW-1:0]       i_q;
	logic [AW-1:0]       j_q;
	logic [CW-1:0]       match_q;
	logic [CW-1:0]       reps_q;
	logic [EW-1:0]       emit_q;
	logic [SW-1:0]       x_q;
	logic                hold_v_q;
	logic [SW-1:0]       hold_q;
	logic                rsp_v_q;
	sui_pkg::rsp_t       rsp_q;

	logic                outer_is_b;
	logic [CW-1:0]       n_outer, n_inner;
	logic [SW-1:0]       a_rdata, b_rdata, outer_data, inner_data;
	logic [CW-1:0]       match_nx;
	logic                scan_last;
	logic                cap;
	logic                out_free;
	logic                emit_go;
	logic                wr_a, wr_b;
	logic [AW-1:0]       oaddr, iaddr, a_raddr, b_raddr;
	logic                rsp_load;
	sui_pkg::rsp_t       rsp_d;

	// copies of the current element to emit for a given match count
	function automatic logic [CW-1:0] reps_of(input sui_pkg::cmd_op_t op,
	                                          input logic [CW-1:0] cnt);
		logic [CW-1:0] r;
		case (op)
			sui_pkg::OP_INTER: r = cnt;
			sui_pkg::OP_UNION: r = CW'(1);
			default:           r = (cnt == '0) ? CW'(1) : '0;
		endcase
		return r;
	endfunction

	assign outer_is_b = (op_q == sui_pkg::OP_B_DIFF);
	assign n_outer    = outer_is_b ? cnt_b_q : cnt_a_q;
	assign n_inner    = outer_is_b ? cnt_a_q : cnt_b_q;
	assign outer_data = outer_is_b ? b_rdata : a_rdata;
	assign inner_data = outer_is_b ? a_rdata : b_rdata;
	assign match_nx   = match_q + CW'(inner_data == x_q);
	assign scan_last  = ((CW'(j_q) + CW'(1)) == n_inner);
	assign cap        = (emit_q == EW'(MAX_RES));
	assign out_free   = !rsp_v_q || rsp_ready;
	assign emit_go    = (state_q == sui_pkg::ST_EMIT) && !cap && (reps_q != '0)
	                    && (!hold_v_q || out_free);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sui_pkg::ST_IDLE: begin
				if (head.valid && (head.cmd.op inside {sui_pkg::OP_UNION, sui_pkg::OP_INTER,
				                                       sui_pkg::OP_A_DIFF, sui_pkg::OP_B_DIFF})) begin
					state_d = sui_pkg::ST_OUTER;
				end
			end
			sui_pkg::ST_OUTER: begin
				if (i_q == n_outer) begin
					state_d = (op_q == sui_pkg::OP_UNION) ? sui_pkg::ST_OUTER
					                                      : sui_pkg::ST_FINISH;
				end else begin
					state_d = sui_pkg::ST_OLOAD;
				end
			end
			sui_pkg::ST_OLOAD: begin
				state_d = ((op_q == sui_pkg::OP_UNION) || (n_inner == '0))
				          ? sui_pkg::ST_EMIT : sui_pkg::ST_SCAN;
			end
			sui_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = sui_pkg::ST_EMIT;
				end
			end
			sui_pkg::ST_EMIT: begin
				if (cap) begin
					state_d = sui_pkg::ST_FINISH;
				end else if (reps_q == '0) begin
					state_d = sui_pkg::ST_OUTER;
				end
			end
			sui_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = sui_pkg::ST_IDLE;
				end
			end
			default: state_d = sui_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop   = (state_q == sui_pkg::ST_IDLE) && head.valid;
		wr_a  = pop && (head.cmd.op == sui_pkg::OP_ADD_A) && (cnt_a_q < CW'(SET_DEPTH));
		wr_b  = pop && (head.cmd.op == sui_pkg::OP_ADD_B) && (cnt_b_q < CW'(SET_DEPTH));
		oaddr = i_q[AW-1:0];
		iaddr = (state_q == sui_pkg::ST_SCAN) ? j_q + AW'(1) : '0;
		a_raddr = outer_is_b ? iaddr : oaddr;
		b_raddr = outer_is_b ? oaddr : iaddr;

		rsp_load = (emit_go && hold_v_q) || ((state_q == sui_pkg::ST_FINISH) && out_free);
		rsp_d.member_id = sui_pkg::ID_W'(hold_q);
		rsp_d.empty_res = 1'b0;
		rsp_d.last      = 1'b0;
		if (state_q == sui_pkg::ST_FINISH) begin
			rsp_d.last = 1'b1;
			if (!hold_v_q) begin
				rsp_d.member_id = '0;
				rsp_d.empty_res = 1'b1;
			end
		end
	end

	sui_ram #(.WIDTH(SW), .DEPTH(SET_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (wr_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (head.cmd.id[SW-1:0]),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	sui_ram #(.WIDTH(SW), .DEPTH(SET_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (wr_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (head.cmd.id[SW-1:0]),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == sui_pkg::ST_OLOAD) begin
			x_q <= outer_data;
		end
		if (emit_go) begin
			hold_q <= x_q;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sui_pkg::ST_IDLE;
			op_q     <= sui_pkg::OP_UNION;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			match_q  <= '0;
			reps_q   <= '0;
			emit_q   <= '0;
			hold_v_q <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sui_pkg::ST_IDLE: begin
					if (pop) begin
						if (head.cmd.op == sui_pkg::OP_CLEAR) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
						end
						if (wr_a) begin
							cnt_a_q <= cnt_a_q + CW'(1);
						end
						if (wr_b) begin
							cnt_b_q <= cnt_b_q + CW'(1);
						end
						op_q   <= head.cmd.op;
						i_q    <= '0;
						emit_q <= '0;
					end
				end
				sui_pkg::ST_OUTER: begin
					// union: after all of A, continue as B minus A
					if ((i_q == n_outer) && (op_q == sui_pkg::OP_UNION)) begin
						op_q <= sui_pkg::OP_B_DIFF;
						i_q  <= '0;
					end
				end
				sui_pkg::ST_OLOAD: begin
					match_q <= '0;
					j_q     <= '0;
					reps_q  <= reps_of(op_q, '0);
				end
				sui_pkg::ST_SCAN: begin
					match_q <= match_nx;
					j_q     <= j_q + AW'(1);
					if (scan_last) begin
						reps_q <= reps_of(op_q, match_nx);
					end
				end
				sui_pkg::ST_EMIT: begin
					if (emit_go) begin
						hold_v_q <= 1'b1;
						reps_q   <= reps_q - CW'(1);
						emit_q   <= emit_q + EW'(1);
					end else if (!cap && (reps_q == '0)) begin
						i_q <= i_q + CW'(1);
					end
				end
				sui_pkg::ST_FINISH: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
					end
				end
				default: ;
			endcase

			if (rsp_load) begin
				rsp_v_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/sui_checker.sv @@
// sui_checker: port-level assertions for the top level, attached by bind.
// Depends on sui_pkg and set_union_intersect_difference.
module sui_checker #(
	parameter int ID_BITS = sui_pkg::ID_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input sui_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sui_pkg::rsp_t rsp
);

	localparam int SW = (ID_BITS < sui_pkg::ID_W) ? ID_BITS : sui_pkg::ID_W;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request item dropped or changed while waiting");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("result changed while stalled");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.empty_res |-> rsp.last && (rsp.member_id == '0))
		else $error("empty result not last or not zero");

	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.member_id >> SW) == '0))
		else $error("member_id wider than ID_BITS");

endmodule

bind set_union_intersect_difference sui_checker #(.ID_BITS(ID_BITS)) u_sui_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ tb/sui_checker.sv @@
`timescale 1ns / 100ps
// sui_tb_checker: watches both channels of set_union_intersect_difference, keeps
// its own copy of lists A and B and checks every result item. Depends on sui_pkg.
module sui_tb_checker #(
	parameter int SET_DEPTH = sui_pkg::SET_DEPTH_DEF,
	parameter int ID_BITS   = sui_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  sui_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  sui_pkg::rsp_t rsp,
	output int            fail_count,
	output int            outstanding
);

	localparam int MAX_ANSWER = 2 * SET_DEPTH;
	localparam logic [sui_pkg::ID_W-1:0] ID_MASK =
		sui_pkg::ID_W'((64'd1 << ID_BITS) - 1);

	logic [sui_pkg::ID_W-1:0] list_a [SET_DEPTH];
	logic [sui_pkg::ID_W-1:0] list_b [SET_DEPTH];
	int                       cnt_a = 0;
	int                       cnt_b = 0;
	int                       errors = 0;
	sui_pkg::rsp_t            answer_q [$];
	sui_pkg::rsp_t            want;

	// true when id sits in the live part of list B (in_b) or list A
	function automatic bit holds_id(logic [sui_pkg::ID_W-1:0] id, bit in_b);
		for (int i = 0; i < (in_b ? cnt_b : cnt_a); i++) begin
			if ((in_b ? list_b[i] : list_a[i]) == id)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// answers are cut off after MAX_ANSWER members
	task automatic add_member(logic [sui_pkg::ID_W-1:0] id, inout int n);
		if (n < MAX_ANSWER) begin
			answer_q.push_back('{member_id: id, empty_res: 1'b0, last: 1'b0});
			n++;
		end
	endtask

	task automatic predict_answer(logic [sui_pkg::MODE_W-1:0] op_code);
		sui_pkg::rsp_t tail;
		int            n;
		n = 0;
		case (op_code)
		sui_pkg::MODE_UNION: begin
			for (int i = 0; i < cnt_a; i++)
				add_member(list_a[i], n);
			for (int i = 0; i < cnt_b; i++)
				if (!holds_id(list_b[i], 1'b0))
					add_member(list_b[i], n);
		end
		sui_pkg::MODE_INTER: begin
			for (int i = 0; i < cnt_a; i++)
				for (int j = 0; j < cnt_b; j++)
					if (list_a[i] == list_b[j])
						add_member(list_a[i], n);
		end
		sui_pkg::MODE_A_DIFF: begin
			for (int i = 0; i < cnt_a; i++)
				if (!holds_id(list_a[i], 1'b1))
					add_member(list_a[i], n);
		end
		default: begin
			for (int i = 0; i < cnt_b; i++)
				if (!holds_id(list_b[i], 1'b0))
					add_member(list_b[i], n);
		end
		endcase
		if (n == 0) begin
			answer_q.push_back('{member_id: '0, empty_res: 1'b1, last: 1'b1});
		end else begin
			tail = answer_q.pop_back();
			tail.last = 1'b1;
			answer_q.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a = 0;
			cnt_b = 0;
			answer_q.delete();
		end else begin
			if (req_valid && req_ready) begin
				case (req.mode)
				sui_pkg::MODE_CLEAR: begin
					cnt_a = 0;
					cnt_b = 0;
				end
				sui_pkg::MODE_ADD_A: begin
					if (cnt_a < SET_DEPTH) begin
						list_a[cnt_a] = req.customer_id & ID_MASK;
						cnt_a++;
					end
				end
				sui_pkg::MODE_ADD_B: begin
					if (cnt_b < SET_DEPTH) begin
						list_b[cnt_b] = req.customer_id & ID_MASK;
						cnt_b++;
					end
				end
				sui_pkg::MODE_UNION, sui_pkg::MODE_INTER,
				sui_pkg::MODE_A_DIFF, sui_pkg::MODE_B_DIFF: begin
					predict_answer(req.mode);
				end
				default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got member_id=%h",
						$time, rsp.member_id, " empty_res=%b last=%b",
						rsp.empty_res, rsp.last);
				end else begin
					want = answer_q.pop_front();
					if (rsp.member_id !== want.member_id || rsp.empty_res !== want.empty_res
						|| rsp.last !== want.last) begin
						errors++;
						$display("%0t: mismatch, expected member_id=%h empty_res=%b last=%b",
							$time, want.member_id, want.empty_res, want.last,
							", got member_id=%h empty_res=%b last=%b",
							rsp.member_id, rsp.empty_res, rsp.last);
					end
				end
			end
		end
		// nonblocking so the stimulus side sees settled values at the next edge
		outstanding <= answer_q.size();
		fail_count <= errors;
	end

endmodule

@@ tb/tb_set_union_intersect_difference.sv @@
`timescale 1ns / 100ps
// tb_set_union_intersect_difference: stimulus and verdict for the set block;
// checking is done by sui_tb_checker. Depends on sui_pkg, sui_tb_checker and the RTL.
module tb_set_union_intersect_difference;

	// spare mode: taken by the block and ignored
	localparam logic [sui_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          rsp_ready = 1'b0;
	logic          req_ready;
	logic          rsp_valid;
	sui_pkg::req_t req       = '0;
	sui_pkg::rsp_t rsp;

	int outstanding;
	int fail_count;
	int idle_pct  = 0;   // chance per cycle that the sender holds off
	int stall_pct = 0;   // chance per cycle that the receiver stalls
	int sent      = 0;   // items that do real work (spare mode not counted)

	// idle / stall mix for each random phase
	int phase_idle  [4] = '{0, 78, 0, 23};
	int phase_stall [4] = '{0, 0, 78, 23};

	set_union_intersect_difference uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sui_tb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: ready is redrawn every cycle, stall chance set per phase
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one item. Random idle cycles come first; valid then stays high
	// with the payload held until the block takes it. Valid is left high on
	// return, so back-to-back items never drop it within one time step.
	task automatic send_item(logic [sui_pkg::MODE_W-1:0] op_code,
	                         logic [sui_pkg::ID_W-1:0] id);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{mode: op_code, customer_id: id};
		do @(posedge clk); while (!req_ready);
		if (op_code != MODE_SPARE)
			sent++;
	endtask

	// Hold off until every expected result has come back. The first edge
	// lets the checker's count catch up with the last accepted item.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// One well-formed sequence: clear, fill A and B, then a few queries.
	// Id flavors: fully random (few matches), all one value (intersection
	// hits the result cap), or a pool of four (mixed duplicates). Fill sizes
	// sometimes exceed the depth so appends to a full list get dropped, and
	// the clear is sometimes skipped so the lists pile up across sequences.
	task automatic run_sequence();
		logic [sui_pkg::ID_W-1:0] pool [4];
		logic [sui_pkg::ID_W-1:0] id;
		int flavor;
		int n_a;
		int n_b;
		flavor = $urandom_range(0, 5);
		for (int i = 0; i < 4; i++)
			pool[i] = sui_pkg::ID_W'($urandom);
		n_a = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 16);
		n_b = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 16);
		if ($urandom_range(0, 7) != 0)
			send_item(sui_pkg::MODE_CLEAR, sui_pkg::ID_W'($urandom));
		while (n_a + n_b > 0) begin
			if (flavor < 2)
				id = sui_pkg::ID_W'($urandom);
			else if (flavor == 2)
				id = pool[0];
			else
				id = pool[$urandom_range(0, 3)];
			if (n_b == 0 || (n_a > 0 && $urandom_range(0, 1) == 1)) begin
				send_item(sui_pkg::MODE_ADD_A, id);
				n_a--;
			end else begin
				send_item(sui_pkg::MODE_ADD_B, id);
				n_b--;
			end
			// noise: spare mode, or a query on a half-built pair of lists
			case ($urandom_range(0, 24))
			0: begin
				send_item(MODE_SPARE, sui_pkg::ID_W'($urandom));
			end
			1: begin
				send_item(sui_pkg::MODE_UNION + sui_pkg::MODE_W'($urandom_range(0, 3)),
					sui_pkg::ID_W'($urandom));
			end
			default: ;
			endcase
		end
		repeat ($urandom_range(1, 4))
			send_item(sui_pkg::MODE_UNION + sui_pkg::MODE_W'($urandom_range(0, 3)),
				sui_pkg::ID_W'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: queries on empty lists, spare mode, id extremes, a duplicate
		// in A, B members shared with A, then B alone against an empty A
		send_item(sui_pkg::MODE_UNION, 16'h0000);
		send_item(sui_pkg::MODE_INTER, 16'hffff);
		send_item(sui_pkg::MODE_A_DIFF, 16'h0000);
		send_item(sui_pkg::MODE_B_DIFF, 16'hffff);
		send_item(MODE_SPARE, 16'hffff);
		send_item(sui_pkg::MODE_ADD_A, 16'h0000);
		send_item(sui_pkg::MODE_ADD_A, 16'hffff);
		send_item(sui_pkg::MODE_ADD_A, 16'h1234);
		send_item(sui_pkg::MODE_ADD_A, 16'h1234);
		send_item(sui_pkg::MODE_ADD_B, 16'h1234);
		send_item(sui_pkg::MODE_ADD_B, 16'hffff);
		send_item(sui_pkg::MODE_ADD_B, 16'h8000);
		send_item(sui_pkg::MODE_UNION, 16'h0000);
		send_item(sui_pkg::MODE_INTER, 16'h0000);
		send_item(sui_pkg::MODE_A_DIFF, 16'h0000);
		send_item(sui_pkg::MODE_B_DIFF, 16'h0000);
		send_item(sui_pkg::MODE_CLEAR, 16'hffff);
		send_item(sui_pkg::MODE_ADD_B, 16'h5555);
		send_item(sui_pkg::MODE_ADD_B, 16'haaaa);
		send_item(sui_pkg::MODE_A_DIFF, 16'h0000);
		send_item(sui_pkg::MODE_UNION, 16'h0000);
		send_item(sui_pkg::MODE_INTER, 16'h0000);

		// random phases, each ending with a full drain before the idle mix changes
		for (int p = 0; p < 4; p++) begin
			idle_pct <= phase_idle[p];
			stall_pct <= phase_stall[p];
			while (sent < (p + 1) * 100)
				run_sequence();
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog: fails and ends a run that hangs
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
